// File: sv/lbfp_pkg.sv
// lbfp_pkg: shared codes, field widths and status types for the bit-field packer
// no dependencies; used by every module of the packer
package lbfp_pkg;

  localparam int unsigned OpW       = 2;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned BiasW     = 32;
  localparam int unsigned WidthW    = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ByteIdxW  = 16;
  localparam int unsigned PendW     = 3;
  localparam int unsigned InTdataW  = 112;
  localparam int unsigned OutTdataW = 24;

  localparam int unsigned OpLsb     = 0;
  localparam int unsigned ValueLsb  = OpLsb + OpW;
  localparam int unsigned BiasLsb   = ValueLsb + ValueW;
  localparam int unsigned WidthLsb  = BiasLsb + BiasW;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_MARKER = 2'd1,
    OP_FINISH = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  typedef struct packed {
    logic [PendW-1:0] pend_cnt;
    logic             idle;
  } back_status_t;

endpackage

// File: sv/lbfp_front.sv
// lbfp_front: accepts items, applies bias, clamps and masks the width, classifies
// depends on lbfp_pkg; feeds lbfp_fifo
module lbfp_front #(
  parameter int unsigned MAX_FIELD_BITS = 64,
  parameter int unsigned CW             = $clog2(MAX_FIELD_BITS + 1)
) (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lbfp_pkg::InTdataW-1:0]     s_axis_tdata,
  input  lbfp_pkg::queue_status_t           q_st_i,
  output logic                              push_o,
  output lbfp_pkg::kind_e                   kind_o,
  output logic [CW-1:0]                     nbits_o,
  output logic [MAX_FIELD_BITS-1:0]         data_o
);

  lbfp_pkg::op_e                  op;
  logic [lbfp_pkg::ValueW-1:0]    value;
  logic [lbfp_pkg::BiasW-1:0]     bias;
  logic [lbfp_pkg::WidthW-1:0]    width;
  logic [lbfp_pkg::ValueW-1:0]    sum;
  logic [MAX_FIELD_BITS-1:0]      raw;
  logic [MAX_FIELD_BITS-1:0]      mask;
  logic [CW-1:0]                  wc;
  logic                           accept;

  always_comb begin
    op    = lbfp_pkg::op_e'(s_axis_tdata[lbfp_pkg::OpLsb +: lbfp_pkg::OpW]);
    value = s_axis_tdata[lbfp_pkg::ValueLsb +: lbfp_pkg::ValueW];
    bias  = s_axis_tdata[lbfp_pkg::BiasLsb +: lbfp_pkg::BiasW];
    width = s_axis_tdata[lbfp_pkg::WidthLsb +: lbfp_pkg::WidthW];
    sum   = value + {{(lbfp_pkg::ValueW - lbfp_pkg::BiasW){1'b0}}, bias};
    if (width > lbfp_pkg::WidthW'(MAX_FIELD_BITS)) begin
      wc = CW'(MAX_FIELD_BITS);
    end else begin
      wc = CW'(width);
    end
    mask = ~({MAX_FIELD_BITS{1'b1}} << wc);
    raw  = (op == lbfp_pkg::OP_MARKER) ? {MAX_FIELD_BITS{1'b1}} : sum[MAX_FIELD_BITS-1:0];
  end

  assign s_axis_tready = ~q_st_i.full;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign kind_o        = (op == lbfp_pkg::OP_FINISH) ? lbfp_pkg::KIND_FINISH
                                                      : lbfp_pkg::KIND_APPEND;
  assign nbits_o       = wc;
  assign data_o        = raw & mask;

  always_comb begin
    unique case (op)
      lbfp_pkg::OP_APPEND, lbfp_pkg::OP_MARKER: push_o = accept && (wc != '0);
      lbfp_pkg::OP_FINISH:                      push_o = accept;
      default:                                  push_o = 1'b0;
    endcase
  end

endmodule

// File: sv/lbfp_fifo.sv
// lbfp_fifo: short register queue between front and back of the packer
// depends on lbfp_pkg for the status type
module lbfp_fifo #(
  parameter int unsigned W     = 72,
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [W-1:0]            wdata_i,
  input  logic                    pop_i,
  output logic [W-1:0]            rdata_o,
  output lbfp_pkg::queue_status_t st_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign st_o.full      = (count_q == NW'(DEPTH));
  assign st_o.not_empty = (count_q != '0);

endmodule

// File: sv/lbfp_back.sv
// lbfp_back: merges queued fields into the partial byte and emits at most one byte a cycle,
// holding while m_axis_tready is low; depends on lbfp_pkg; reads from lbfp_fifo
module lbfp_back #(
  parameter int unsigned MAX_FIELD_BITS = 64,
  parameter int unsigned CW             = $clog2(MAX_FIELD_BITS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lbfp_pkg::queue_status_t           q_st_i,
  input  lbfp_pkg::kind_e                   kind_i,
  input  logic [CW-1:0]                     nbits_i,
  input  logic [MAX_FIELD_BITS-1:0]         data_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lbfp_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  output lbfp_pkg::back_status_t            st_o
);

  localparam int unsigned PW = lbfp_pkg::PendW;
  localparam int unsigned BW = lbfp_pkg::ByteW;
  localparam int unsigned IW = lbfp_pkg::ByteIdxW;

  logic [MAX_FIELD_BITS-1:0] work_data_q, work_data_d;
  logic [CW-1:0]             work_n_q, work_n_d;
  logic [BW-2:0]             cur_q, cur_d;
  logic [PW-1:0]             cnt_q, cnt_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  logic [BW-1:0]             out_byte_q, out_byte_d;
  logic [IW-1:0]             out_idx_q, out_idx_d;
  logic                      out_last_q, out_last_d;

  logic                      can_step, use_head, active, emit, emit_last;
  lbfp_pkg::kind_e           src_kind;
  logic [CW-1:0]             src_n;
  logic [MAX_FIELD_BITS-1:0] src_data;
  logic [PW:0]               room, take, tot;
  logic [BW-1:0]             mask8, ins, merged;

  assign can_step = ~out_valid_q | m_axis_tready;
  assign use_head = (work_n_q == '0);
  assign pop_o    = can_step & use_head & q_st_i.not_empty;
  assign active   = can_step & (~use_head | q_st_i.not_empty);

  always_comb begin
    src_kind = use_head ? kind_i : lbfp_pkg::KIND_APPEND;
    src_n    = use_head ? nbits_i : work_n_q;
    src_data = use_head ? data_i : work_data_q;

    room   = (PW + 1)'(BW) - {1'b0, cnt_q};
    take   = (src_n < CW'(room)) ? src_n[PW:0] : room;
    mask8  = ~({BW{1'b1}} << take);
    ins    = (src_data[BW-1:0] & mask8) << cnt_q;
    merged = {1'b0, cur_q} | ins;
    tot    = {1'b0, cnt_q} + take;

    work_data_d = work_data_q;
    work_n_d    = work_n_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    emit        = 1'b0;
    emit_last   = 1'b0;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;

    if (active) begin
      unique case (src_kind)
        lbfp_pkg::KIND_FINISH: begin
          emit       = (cnt_q != '0);
          emit_last  = 1'b1;
          out_byte_d = {1'b0, cur_q};
          cur_d      = '0;
          cnt_d      = '0;
        end
        default: begin
          work_data_d = src_data >> take;
          work_n_d    = src_n - CW'(take);
          out_byte_d  = merged;
          if (tot == (PW + 1)'(BW)) begin
            emit  = 1'b1;
            cur_d = '0;
            cnt_d = '0;
          end else begin
            cur_d = merged[BW-2:0];
            cnt_d = tot[PW-1:0];
          end
        end
      endcase
      if (emit) begin
        out_idx_d = idx_q;
        if (idx_q != {IW{1'b1}}) begin
          idx_d = idx_q + 1'b1;
        end
      end
      out_last_d = emit_last;
      if (src_kind == lbfp_pkg::KIND_FINISH) begin
        idx_d = '0;
      end
    end
    if (can_step) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_n_q    <= '0;
      cur_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_n_q    <= work_n_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_data_q <= work_data_d;
    out_byte_q  <= out_byte_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_idx_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;
  assign st_o.pend_cnt = cnt_q;
  assign st_o.idle     = use_head;

endmodule

// File: sv/lsb_first_bit_field_packer_top.sv
// lsb_first_bit_field_packer_top: top level of the lsb-first bit-field packer
// depends on lbfp_pkg, lbfp_front, lbfp_fifo and lbfp_back
//
// Usage:
//   s_axis carries one command per item: append a field (value plus bias, low
//   width bits), append an all-ones end marker of width bits, or finish the
//   record. m_axis carries packed bytes, earlier bits in lower positions, with
//   the byte's index in the record; tlast marks the padded byte of a finish.
//   With the byte engine idle, the first byte of an item passes the queue write
//   at the accepting edge, then the output register, before showing on m_axis.
//   The byte engine takes a field chunk by chunk, cut at byte boundaries, and a
//   finish as a single step; a 64-bit field gives 8 chunks with no bits pending
//   and 9 otherwise. Zero-width fields and the unused code never enter the
//   queue. The two-entry queue lets the input keep flowing meanwhile. A finish
//   with no pending bits gives no byte but still restarts the index.
//   When the receiver stalls, the byte engine holds and the queue fills; once
//   it is full s_axis_tready drops. Reset empties the queue, clears the
//   partial byte and the byte index, and drops m_axis_tvalid.
module lsb_first_bit_field_packer_top #(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operation[1:0], value[65:2], bias[97:66], width[104:98], zero fill above
  input  logic [lbfp_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // data_byte[7:0], byte_index[23:8]
  output logic [lbfp_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int unsigned CW     = $clog2(MAX_FIELD_BITS + 1);
  localparam int unsigned EW     = 1 + CW + MAX_FIELD_BITS;
  localparam int unsigned QDepth = 2;

  lbfp_pkg::queue_status_t   q_st;
  lbfp_pkg::back_status_t    bk_st;
  logic                      push, pop;
  lbfp_pkg::kind_e           f_kind;
  logic [CW-1:0]             f_nbits;
  logic [MAX_FIELD_BITS-1:0] f_data;
  logic [EW-1:0]             q_rdata;

  lbfp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .CW            (CW)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_st_i       (q_st),
    .push_o       (push),
    .kind_o       (f_kind),
    .nbits_o      (f_nbits),
    .data_o       (f_data)
  );

  lbfp_fifo #(
    .W    (EW),
    .DEPTH(QDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({f_kind, f_nbits, f_data}),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .st_o   (q_st)
  );

  lbfp_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .CW            (CW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_st_i       (q_st),
    .kind_i       (lbfp_pkg::kind_e'(q_rdata[EW-1])),
    .nbits_i      (q_rdata[MAX_FIELD_BITS +: CW]),
    .data_i       (q_rdata[MAX_FIELD_BITS-1:0]),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .st_o         (bk_st)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_st.full |-> !s_axis_tready)
    else $error("input accepted while queue full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_st.not_empty)
    else $error("queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (bk_st.pend_cnt == '0))
    else $error("partial bits left after record finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> !q_st.full)
    else $error("queue full after pop without push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_st.idle |-> !pop)
    else $error("queue popped while a field is still being split");

endmodule

// File: tb/sv/lsb_first_bit_field_packer_top_test.sv
// lsb_first_bit_field_packer_top_test: self-checking testbench for the lsb-first bit-field packer
// depends on lbfp_pkg and lsb_first_bit_field_packer_top; predicts every packed byte and checks
// data, index and last flag as each byte leaves the packer
module lsb_first_bit_field_packer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FieldMax   = 64;
  localparam int unsigned CycleLimit = 40000;
  localparam int unsigned RandItems  = 270;
  localparam int unsigned LongFields = 20;
  localparam int unsigned MaxPrinted = 50;

  typedef struct packed {
    logic [lbfp_pkg::ByteW-1:0]    data;
    logic [lbfp_pkg::ByteIdxW-1:0] idx;
    logic                          last;
  } packed_byte_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [lbfp_pkg::InTdataW-1:0]  s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [lbfp_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  logic tx_idle_en;
  logic rx_idle_en;

  packed_byte_t                  packed_byte_q[$];
  logic [6:0]                    model_pend_bits;
  logic [lbfp_pkg::PendW-1:0]    model_pend_cnt;
  logic [lbfp_pkg::ByteIdxW-1:0] model_byte_idx;

  int unsigned cycle_count;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned bytes_checked;
  int unsigned records_closed;

  lsb_first_bit_field_packer_top #(
    .MAX_FIELD_BITS(FieldMax)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s want %0h got %0h", cycle_count, what, want, got);
    end
  endtask

  task automatic emit_byte(logic [lbfp_pkg::ByteW-1:0] b, logic last);
    packed_byte_q.push_back('{data: b, idx: model_byte_idx, last: last});
    if (model_byte_idx != '1) begin
      model_byte_idx++;
    end
  endtask

  task automatic pack_command(lbfp_pkg::op_e op, logic [63:0] value, logic [31:0] bias,
                              logic [lbfp_pkg::WidthW-1:0] width);
    logic [63:0]                field;
    logic [lbfp_pkg::ByteW-1:0] acc;
    int unsigned                nbits;
    int unsigned                cnt;
    nbits = (width > FieldMax) ? FieldMax : int'(width);
    case (op)
      lbfp_pkg::OP_APPEND: field = value + {32'd0, bias};
      lbfp_pkg::OP_MARKER: field = '1;
      lbfp_pkg::OP_FINISH: begin
        if (model_pend_cnt != '0) begin
          emit_byte({1'b0, model_pend_bits}, 1'b1);
        end
        model_pend_bits = '0;
        model_pend_cnt  = '0;
        model_byte_idx  = '0;
        records_closed++;
        return;
      end
      default: return;
    endcase
    acc = {1'b0, model_pend_bits};
    cnt = int'(model_pend_cnt);
    for (int i = 0; i < nbits; i++) begin
      acc[cnt] = field[i];
      cnt++;
      if (cnt == lbfp_pkg::ByteW) begin
        emit_byte(acc, 1'b0);
        acc = '0;
        cnt = 0;
      end
    end
    model_pend_bits = acc[6:0];
    model_pend_cnt  = cnt[lbfp_pkg::PendW-1:0];
  endtask

  task automatic send_cmd(lbfp_pkg::op_e op, logic [63:0] value, logic [31:0] bias,
                          logic [lbfp_pkg::WidthW-1:0] width);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    // zero fill, width, bias, value, operation
    s_axis_tdata  <= {7'd0, width, bias, value, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pack_command(op, value, bias, width);
    items_sent++;
  endtask

  function automatic logic [63:0] rand_value();
    return {$urandom(), $urandom()};
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= !(rx_idle_en && $urandom_range(0, 99) < 18);
  end

  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (packed_byte_q.size() == 0) begin
        report_mismatch("byte with none expected", '0, 64'(m_axis_tdata));
      end else begin
        want = packed_byte_q.pop_front();
        bytes_checked++;
        if (m_axis_tdata[lbfp_pkg::ByteW-1:0] !== want.data) begin
          report_mismatch("data_byte", 64'(want.data),
                          64'(m_axis_tdata[lbfp_pkg::ByteW-1:0]));
        end
        if (m_axis_tdata[lbfp_pkg::ByteW+:lbfp_pkg::ByteIdxW] !== want.idx) begin
          report_mismatch("byte_index", 64'(want.idx),
                          64'(m_axis_tdata[lbfp_pkg::ByteW+:lbfp_pkg::ByteIdxW]));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last", 64'(want.last), 64'(m_axis_tlast));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               packed_byte_q.size());
      $display("** lsb_first_bit_field_packer_top: FAILED **");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_cmd(lbfp_pkg::OP_APPEND, '1, '1, 7'd0);
    send_cmd(lbfp_pkg::OP_APPEND, 64'd1, 32'd0, 7'd1);
    send_cmd(lbfp_pkg::OP_APPEND, 64'h8000_0000_0000_0000, 32'd0, 7'd64);
    send_cmd(lbfp_pkg::OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, '1, 7'd64);
    // bias overflow wraps
    send_cmd(lbfp_pkg::OP_APPEND, '1, '1, 7'd64);
    send_cmd(lbfp_pkg::OP_APPEND, -64'd5, 32'd5, 7'd7);
    send_cmd(lbfp_pkg::OP_FINISH, rand_value(), $urandom(), 7'd0);
    send_cmd(lbfp_pkg::OP_FINISH, rand_value(), $urandom(), 7'd64);
  endtask

  task automatic test_special_cases();
    // widths above the limit clamp
    send_cmd(lbfp_pkg::OP_APPEND, rand_value(), $urandom(), 7'd127);
    send_cmd(lbfp_pkg::OP_APPEND, rand_value(), $urandom(), 7'd65);
    send_cmd(lbfp_pkg::OP_MARKER, rand_value(), $urandom(), 7'd64);
    send_cmd(lbfp_pkg::OP_MARKER, '0, '0, 7'd3);
    send_cmd(lbfp_pkg::OP_MARKER, '0, '0, 7'd127);
    send_cmd(lbfp_pkg::OP_MARKER, '1, '1, 7'd0);
    send_cmd(lbfp_pkg::OP_UNUSED, rand_value(), $urandom(), 7'd40);
    send_cmd(lbfp_pkg::OP_APPEND, 64'd5, 32'd0, 7'd3);
    send_cmd(lbfp_pkg::OP_UNUSED, '1, '1, 7'd127);
    send_cmd(lbfp_pkg::OP_FINISH, '0, '0, 7'd0);
    send_cmd(lbfp_pkg::OP_APPEND, 64'h00A5, 32'd0, 7'd8);
    // nothing pending, index still restarts
    send_cmd(lbfp_pkg::OP_FINISH, '0, '0, 7'd0);
  endtask

  task automatic test_long_record();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < LongFields; i++) begin
      if (i % 3 == 0) begin
        send_cmd(lbfp_pkg::OP_MARKER, rand_value(), $urandom(), 7'd64);
      end else begin
        send_cmd(lbfp_pkg::OP_APPEND, rand_value(), $urandom(), 7'd64);
      end
    end
    send_cmd(lbfp_pkg::OP_APPEND, rand_value(), $urandom(), 7'd5);
    send_cmd(lbfp_pkg::OP_FINISH, '0, '0, 7'd0);
    send_cmd(lbfp_pkg::OP_APPEND, rand_value(), $urandom(), 7'd8);
    send_cmd(lbfp_pkg::OP_FINISH, '0, '0, 7'd0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_records();
    int unsigned                 counted;
    int unsigned                 nfields;
    int unsigned                 pick;
    logic [lbfp_pkg::WidthW-1:0] width;
    logic [63:0]                 value;
    logic [31:0]                 bias;
    counted = 0;
    while (counted < RandItems) begin
      tx_idle_en = !(counted >= 120 && counted < 200);
      rx_idle_en = tx_idle_en;
      if ($urandom_range(0, 99) < 10) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          send_cmd(lbfp_pkg::OP_UNUSED, rand_value(), $urandom(),
                   lbfp_pkg::WidthW'($urandom()));
        end else begin
          send_cmd(lbfp_pkg::op_e'($urandom_range(0, 2)), rand_value(), $urandom(),
                   lbfp_pkg::WidthW'($urandom()));
          counted++;
        end
      end else begin
        nfields = $urandom_range(1, 6);
        for (int f = 0; f < nfields; f++) begin
          pick = $urandom_range(0, 99);
          if (pick < 85) begin
            width = lbfp_pkg::WidthW'($urandom_range(0, 64));
          end else if (pick < 92) begin
            width = lbfp_pkg::WidthW'(64);
          end else begin
            width = lbfp_pkg::WidthW'($urandom_range(65, 127));
          end
          pick = $urandom_range(0, 9);
          value = (pick == 0) ? -64'($urandom_range(1, 1000)) : rand_value();
          bias = (pick == 0) ? 32'd1000 : (pick == 1) ? '1 : $urandom();
          if ($urandom_range(0, 99) < 75) begin
            send_cmd(lbfp_pkg::OP_APPEND, value, bias, width);
          end else begin
            send_cmd(lbfp_pkg::OP_MARKER, value, bias, width);
          end
          counted++;
        end
        if ($urandom_range(0, 99) < 90) begin
          send_cmd(lbfp_pkg::OP_FINISH, rand_value(), $urandom(),
                   lbfp_pkg::WidthW'($urandom()));
          counted++;
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    model_pend_bits = '0;
    model_pend_cnt  = '0;
    model_byte_idx  = '0;
    cycle_count     = 0;
    errors          = 0;
    items_sent      = 0;
    bytes_checked   = 0;
    records_closed  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_special_cases();
    test_long_record();
    test_random_records();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (packed_byte_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (packed_byte_q.size() != 0) begin
      void'(packed_byte_q.pop_front());
      report_mismatch("byte never delivered", '0, '0);
    end

    $display("sent %0d items over %0d records, checked %0d packed bytes", items_sent,
             records_closed, bytes_checked);
    $display("covered width clamping, end markers, bias wrap, empty finishes and long records");
    if (errors == 0) begin
      $display("** lsb_first_bit_field_packer_top: PASSED **");
    end else begin
      $display("** lsb_first_bit_field_packer_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/lbfp_pkg.sv
sv/lbfp_front.sv
sv/lbfp_fifo.sv
sv/lbfp_back.sv
sv/lsb_first_bit_field_packer_top.sv
tb/sv/lsb_first_bit_field_packer_top_test.sv
